@@ rtl/core/dmm_pkg.sv @@
`default_nettype none

package dmm_pkg;

  localparam int unsigned MEM_ADDR_BITS_DEF = 16;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [2:0] LK_NONE   = 3'd0;
  localparam logic [2:0] LK_WORD   = 3'd1;
  localparam logic [2:0] LK_BYTE_U = 3'd2;
  localparam logic [2:0] LK_HALF_S = 3'd3;
  localparam logic [2:0] LK_HALF_U = 3'd4;
  localparam logic [2:0] LK_BYTE_S = 3'd5;

  localparam logic [31:0] MEM_BASE      = 32'h8000_0000;
  localparam logic [31:0] WINDOW_END    = 32'h8fff_ffff;
  localparam logic [31:0] CONSOLE_ADDR  = 32'ha000_03f8;
  localparam logic [31:0] TIMER_LO_ADDR = 32'ha000_0048;
  localparam logic [31:0] TIMER_HI_ADDR = 32'ha000_004c;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [2:0]  load_kind;
    logic [2:0]  store_bytes;
  } dmm_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        uart_valid;
    logic [7:0]  uart_byte;
  } dmm_rsp_t;

  // What the response stage needs from the request, registered on acceptance.
  typedef struct packed {
    logic [2:0]  kind;
    logic        mem_load;
    logic [1:0]  lane0;
    logic [3:0]  byte_ok;
    logic [31:0] fixed_data;
    logic        uart_valid;
    logic [7:0]  uart_byte;
  } dmm_info_t;

endpackage

`default_nettype wire

@@ rtl/core/dmm_ram.sv @@
`default_nettype none

module dmm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dmm_decode.sv @@
`default_nettype none

module dmm_decode #(
  parameter int unsigned MEM_ADDR_BITS = dmm_pkg::MEM_ADDR_BITS_DEF
) (
  input  wire dmm_pkg::dmm_req_t                 req,
  input  wire logic                              accept,
  input  wire logic [63:0]                       timer,
  output logic      [3:0]                        bank_en,
  output logic      [3:0]                        bank_we,
  output logic      [3:0][MEM_ADDR_BITS-3:0]     bank_row,
  output logic      [3:0][7:0]                   bank_wdata,
  output dmm_pkg::dmm_info_t                     info
);

  logic [31:0]      off;
  logic             is_console;
  logic             is_store;
  logic             is_load;
  logic             mem_load;
  logic [2:0]       nbytes;
  logic [3:0][1:0]  lane_idx;
  logic [3:0][31:0] boff;
  logic [3:0][31:0] loff;
  logic [3:0]       bank_in_mem;
  logic [3:0]       bank_wr;

  always_comb begin
    off        = req.addr - dmm_pkg::MEM_BASE;
    is_console = (req.addr == dmm_pkg::CONSOLE_ADDR);
    is_store   = (req.op == dmm_pkg::OP_STORE) && !is_console;
    is_load    = (req.op == dmm_pkg::OP_LOAD) && (req.load_kind != dmm_pkg::LK_NONE);
    nbytes     = (req.store_bytes > 3'd4) ? 3'd4 : req.store_bytes;
    mem_load   = is_load && (req.addr != dmm_pkg::TIMER_LO_ADDR) &&
                 (req.addr != dmm_pkg::TIMER_HI_ADDR) &&
                 (req.addr >= dmm_pkg::MEM_BASE) && (req.addr < dmm_pkg::WINDOW_END);

    // Byte i of the access lives in bank (off + i) mod 4.
    for (int b = 0; b < 4; b++) begin
      lane_idx[b]    = 2'(b) - off[1:0];
      boff[b]        = off + {30'd0, lane_idx[b]};
      bank_in_mem[b] = (boff[b][31:MEM_ADDR_BITS] == '0);
      bank_wr[b]     = is_store && ({1'b0, lane_idx[b]} < nbytes) && bank_in_mem[b];
      bank_we[b]     = accept && bank_wr[b];
      bank_en[b]     = accept && (bank_wr[b] || (mem_load && bank_in_mem[b]));
      bank_row[b]    = boff[b][MEM_ADDR_BITS-1:2];
      bank_wdata[b]  = req.wdata[8*lane_idx[b] +: 8];
    end

    for (int i = 0; i < 4; i++) begin
      loff[i]         = off + 32'(i);
      info.byte_ok[i] = (loff[i][31:MEM_ADDR_BITS] == '0);
    end

    info.kind     = req.load_kind;
    info.mem_load = mem_load;
    info.lane0    = off[1:0];
    if (is_load && (req.addr == dmm_pkg::TIMER_LO_ADDR)) begin
      info.fixed_data = timer[31:0];
    end else if (is_load && (req.addr == dmm_pkg::TIMER_HI_ADDR)) begin
      info.fixed_data = timer[63:32];
    end else begin
      info.fixed_data = '0;
    end
    info.uart_valid = (req.op == dmm_pkg::OP_STORE) && is_console;
    info.uart_byte  = info.uart_valid ? req.wdata[7:0] : 8'h00;
  end

endmodule

`default_nettype wire

@@ rtl/core/dmm_format.sv @@
`default_nettype none

module dmm_format (
  input  wire dmm_pkg::dmm_info_t info,
  input  wire logic [3:0][7:0]    bank_rdata,
  output dmm_pkg::dmm_rsp_t       rsp
);

  logic [3:0][7:0] bytes;
  logic [1:0]      lane;
  logic [31:0]     word;

  always_comb begin
    lane = '0;
    for (int i = 0; i < 4; i++) begin
      lane     = info.lane0 + 2'(i);
      bytes[i] = info.byte_ok[i] ? bank_rdata[lane] : 8'h00;
    end
    word = bytes;

    if (!info.mem_load) begin
      rsp.read_data = info.fixed_data;
    end else begin
      unique case (info.kind)
        dmm_pkg::LK_WORD:   rsp.read_data = word;
        dmm_pkg::LK_BYTE_U: rsp.read_data = {24'd0, word[7:0]};
        dmm_pkg::LK_HALF_S: rsp.read_data = {{16{word[15]}}, word[15:0]};
        dmm_pkg::LK_HALF_U: rsp.read_data = {16'd0, word[15:0]};
        dmm_pkg::LK_BYTE_S: rsp.read_data = {{24{word[7]}}, word[7:0]};
        default:            rsp.read_data = '0;
      endcase
    end
    rsp.uart_valid = info.uart_valid;
    rsp.uart_byte  = info.uart_byte;
  end

endmodule

`default_nettype wire

@@ rtl/core/riscv_data_memory_with_mmio.sv @@
// RV32 data memory with console port and 64-bit microsecond timer.
//
// Request channel req/req_valid/req_ready carries loads, stores and timer
// ticks; response channel rsp/rsp_valid/rsp_ready returns exactly one
// transaction per request, in order.
// Memory is four byte-wide banks of 2^(MEM_ADDR_BITS-2) rows; an unaligned
// access of up to four bytes touches each bank at most once, so one request
// is accepted per cycle unless a stall drops req_ready. A request is decoded
// and sent to the banks on the cycle it is accepted; the bank read data and
// the s1 stage are registered, and the response register loads on advance.
// Sustained rate: one transaction per cycle while rsp_ready stays high.
// When rsp_ready is low the response register holds, the in-flight request
// waits in its stage, and req_ready drops once both are full.
// Reset clears the timer and the pipeline valids; memory contents are
// undefined until written, and requests are accepted as soon as reset ends.
`default_nettype none

module riscv_data_memory_with_mmio #(
  parameter int unsigned MEM_ADDR_BITS = dmm_pkg::MEM_ADDR_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire dmm_pkg::dmm_req_t req,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output dmm_pkg::dmm_rsp_t      rsp
);

  localparam int unsigned ROWS = 1 << (MEM_ADDR_BITS - 2);

  logic                        accept;
  logic                        advance;
  logic                        s1_valid;
  dmm_pkg::dmm_info_t          s1_info;
  dmm_pkg::dmm_info_t          dec_info;
  dmm_pkg::dmm_rsp_t           fmt_rsp;
  logic [63:0]                 timer;
  logic [3:0]                  bank_en;
  logic [3:0]                  bank_we;
  logic [3:0][MEM_ADDR_BITS-3:0] bank_row;
  logic [3:0][7:0]             bank_wdata;
  logic [3:0][7:0]             bank_rdata;

  assign advance   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || advance;
  assign accept    = req_valid && req_ready;

  dmm_decode #(
    .MEM_ADDR_BITS(MEM_ADDR_BITS)
  ) u_decode (
    .req        (req),
    .accept     (accept),
    .timer      (timer),
    .bank_en    (bank_en),
    .bank_we    (bank_we),
    .bank_row   (bank_row),
    .bank_wdata (bank_wdata),
    .info       (dec_info)
  );

  for (genvar b = 0; b < 4; b++) begin : g_bank
    dmm_ram #(
      .WIDTH(8),
      .DEPTH(ROWS)
    ) u_ram (
      .clk   (clk),
      .en    (bank_en[b]),
      .we    (bank_we[b]),
      .addr  (bank_row[b]),
      .wdata (bank_wdata[b]),
      .rdata (bank_rdata[b])
    );
  end

  dmm_format u_format (
    .info       (s1_info),
    .bank_rdata (bank_rdata),
    .rsp        (fmt_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
      timer     <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (accept && (req.op == dmm_pkg::OP_TICK)) begin
        timer <= timer + 64'd1;
      end
    end
    if (accept) begin
      s1_info <= dec_info;
    end
    if (advance) begin
      rsp <= fmt_rsp;
    end
  end

  a_bank_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    (bank_en != 4'b0000) |-> accept)
    else $error("bank access without an accepted request");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_info))
    else $error("in-flight request lost while stalled");

  a_advance_fills_rsp: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp_valid)
    else $error("advanced request did not reach response register");

  a_timer_tick: assert property (@(posedge clk) disable iff (rst)
    accept && (req.op == dmm_pkg::OP_TICK) |=> timer == $past(timer) + 64'd1)
    else $error("timer did not advance on tick");

  a_timer_hold: assert property (@(posedge clk) disable iff (rst)
    !(accept && (req.op == dmm_pkg::OP_TICK)) |=> timer == $past(timer))
    else $error("timer changed without tick");

endmodule

`default_nettype wire
